// ----- src/hci_pkg.sv -----
// Shared types, constants and per-level functions of the Hilbert index unit.
package hci_pkg;

    localparam int HCI_COORD_BITS       = 16;
    localparam int HCI_CODE_BITS        = 32;
    localparam int HCI_TAB_ENTRIES      = 8;
    localparam int HCI_DIGIT_BITS       = 3;
    localparam int HCI_LEVEL_BITS       = 5;
    localparam int HCI_MAX_LEVELS_3D    = 10;
    localparam int HCI_MAX_LEVELS_2D    = 16;
    localparam int HCI_LEVELS_PER_STAGE = 2;
    localparam int HCI_STAGES           = HCI_MAX_LEVELS_2D / HCI_LEVELS_PER_STAGE;
    localparam int HCI_CFG_INDEX_BITS   = 4;
    localparam int HCI_CFG_DATA_BITS    = 5;

    typedef logic [HCI_DIGIT_BITS-1:0]                      t_digit;
    typedef logic [HCI_TAB_ENTRIES-1:0][HCI_DIGIT_BITS-1:0] t_tab;
    typedef logic [HCI_CODE_BITS-1:0]                       t_code;
    typedef logic [HCI_LEVEL_BITS-1:0]                      t_levels;

    typedef enum logic [HCI_CFG_INDEX_BITS-1:0] {
        CFG_THREE_D = 4'd0,
        CFG_DEPTH   = 4'd1
    } t_cfg_index;

    typedef struct packed {
        logic    three_d;
        t_levels levels;
    } t_cfg;

    typedef struct packed {
        logic valid;
        logic ready;
    } t_hs;

    typedef struct packed {
        t_digit digit;
        t_tab   tab;
    } t_level_res;

    // vertex -> digit at the start of every point
    localparam t_tab HCI_TAB_INIT_3D = {3'd0, 3'd1, 3'd3, 3'd2, 3'd7, 3'd6, 3'd4, 3'd5};
    localparam t_tab HCI_TAB_INIT_2D = {3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd3, 3'd2};

    function automatic t_digit hci_swap(input t_digit val, input t_digit p, input t_digit q);
        t_digit res;
        res = val;
        if (val == p) res = q;
        else if (val == q) res = p;
        return res;
    endfunction

    // Relabel one table entry after the digit of this level is taken.
    function automatic t_digit hci_relabel(input logic three_d, input t_digit digit,
                                           input t_digit val);
        t_digit res;
        res = val;
        if (three_d) begin
            case (digit) inside
                3'd0:       res = hci_swap(hci_swap(val, 3'd1, 3'd7), 3'd2, 3'd4);
                3'd1, 3'd2: res = hci_swap(hci_swap(val, 3'd2, 3'd6), 3'd3, 3'd7);
                3'd3, 3'd4: res = hci_swap(hci_swap(val, 3'd0, 3'd2), 3'd5, 3'd7);
                3'd5, 3'd6: res = hci_swap(hci_swap(val, 3'd0, 3'd4), 3'd1, 3'd5);
                default:    res = hci_swap(hci_swap(val, 3'd0, 3'd6), 3'd3, 3'd5);
            endcase
        end else begin
            case (digit)
                3'd0:    res = hci_swap(val, 3'd1, 3'd3);
                3'd3:    res = hci_swap(val, 3'd0, 3'd2);
                default: res = val;
            endcase
        end
        return res;
    endfunction

    function automatic t_level_res hci_level(input logic three_d, input t_tab tab,
                                             input t_digit vert);
        t_level_res res;
        res.digit = tab[vert];
        for (int k = 0; k < HCI_TAB_ENTRIES; k++) begin
            res.tab[k] = hci_relabel(three_d, res.digit, tab[k]);
        end
        return res;
    endfunction

endpackage

// ----- src/hci_cfg.sv -----
// Configuration registers of the Hilbert index unit and depth saturation.
module hci_cfg
    import hci_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [HCI_CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [HCI_CFG_DATA_BITS-1:0]  i_cfg_data,
    output logic                          o_cfg_ready,
    output t_cfg                          o_cfg
);

    logic    r_three_d;
    t_levels r_depth;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_three_d <= 1'b1;
            r_depth   <= t_levels'(HCI_MAX_LEVELS_3D);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_THREE_D: r_three_d <= i_cfg_data[0];
                CFG_DEPTH:   r_depth   <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    // saturate depth to the deepest level the code word holds
    always_comb begin
        o_cfg.three_d = r_three_d;
        if (r_three_d) begin
            o_cfg.levels = (r_depth > t_levels'(HCI_MAX_LEVELS_3D))
                         ? t_levels'(HCI_MAX_LEVELS_3D) : r_depth;
        end else begin
            o_cfg.levels = (r_depth > t_levels'(HCI_MAX_LEVELS_2D))
                         ? t_levels'(HCI_MAX_LEVELS_2D) : r_depth;
        end
    end

endmodule

// ----- src/hci_stage.sv -----
// One pipeline stage: resolves a fixed pair of curve levels and registers the result.
module hci_stage
    import hci_pkg::*;
#(
    parameter int COORD_BITS  = HCI_COORD_BITS,
    parameter int FIRST_LEVEL = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  t_hs                   i_hs_up,
    input  logic [COORD_BITS-1:0] i_pos_x,
    input  logic [COORD_BITS-1:0] i_pos_y,
    input  logic [COORD_BITS-1:0] i_pos_z,
    input  t_tab                  i_tab,
    input  t_code                 i_code,
    output logic                  o_ready,
    output logic                  o_valid,
    output logic [COORD_BITS-1:0] o_pos_x,
    output logic [COORD_BITS-1:0] o_pos_y,
    output logic [COORD_BITS-1:0] o_pos_z,
    output t_tab                  o_tab,
    output t_code                 o_code
);

    localparam int L = HCI_LEVELS_PER_STAGE;

    logic                  r_valid;
    logic [COORD_BITS-1:0] r_pos_x, r_pos_y, r_pos_z;
    t_tab                  r_tab;
    t_code                 r_code;
    t_tab                  tab_c  [0:L];
    t_code                 code_c [0:L];
    logic                  adv;

    assign tab_c[0]  = i_tab;
    assign code_c[0] = i_code;

    genvar j;
    generate
        for (j = 0; j < L; j++) begin : g_lvl
            localparam int      BIT_IDX = COORD_BITS - 1 - FIRST_LEVEL - j;
            localparam t_levels LVL     = t_levels'(FIRST_LEVEL + j);
            logic [2:0] inv_bits;
            t_digit     vert;
            t_level_res res;

            // cell bits past the coordinate precision read as zero
            if (BIT_IDX >= 0) begin : g_in
                assign inv_bits = ~{i_pos_z[BIT_IDX], i_pos_y[BIT_IDX], i_pos_x[BIT_IDX]};
            end else begin : g_out
                assign inv_bits = 3'b111;
            end

            assign vert = {inv_bits[2] & i_cfg.three_d, inv_bits[1:0]};
            assign res  = hci_level(i_cfg.three_d, tab_c[j], vert);
            assign tab_c[j+1] = res.tab;

            always_comb begin
                if (LVL >= i_cfg.levels) begin
                    code_c[j+1] = code_c[j];
                end else if (i_cfg.three_d) begin
                    code_c[j+1] = {code_c[j][HCI_CODE_BITS-4:0], res.digit};
                end else begin
                    code_c[j+1] = {code_c[j][HCI_CODE_BITS-3:0], res.digit[1:0]};
                end
            end
        end
    endgenerate

    assign o_ready = !r_valid || i_hs_up.ready;
    assign adv     = o_ready && i_hs_up.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_hs_up.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pos_x <= i_pos_x;
            r_pos_y <= i_pos_y;
            r_pos_z <= i_pos_z;
            r_tab   <= tab_c[L];
            r_code  <= code_c[L];
        end
    end

    assign o_valid = r_valid;
    assign o_pos_x = r_pos_x;
    assign o_pos_y = r_pos_y;
    assign o_pos_z = r_pos_z;
    assign o_tab   = r_tab;
    assign o_code  = r_code;

endmodule

// ----- src/hilbert_curve_index_unit.sv -----
// Top level of the Hilbert curve index unit: config registers and the level pipeline.
//
// Usage: a request carries one point (i_pos_x, i_pos_y, i_pos_z) and is taken
// at a clock edge with i_valid high and o_stall low. Each request yields exactly
// one o_hilbert_code, offered with o_valid and taken at an edge where i_stall
// is low. The coarsest level gives the most significant digit.
// Each of the HCI_STAGES (8) stages resolves two curve levels, so
// the eight stages cover the sixteen levels of 2D mode and the ten of 3D mode.
// One request is taken per cycle while o_stall is low.
// Configuration: index 0 selects 3D (1) or 2D (0), index 1 sets the depth,
// saturated to 10 in 3D and 16 in 2D. o_cfg_ready is always high. Write only
// while the pipeline is empty.
// Reset (i_rst_n low, synchronous) empties the pipeline and restores 3D mode
// with depth 10. When the receiver holds i_stall, the result stays on the
// outputs, stages behind it fill their bubbles, and o_stall rises once every
// stage holds a request.
module hilbert_curve_index_unit
    import hci_pkg::*;
#(
    parameter int COORD_BITS = HCI_COORD_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [COORD_BITS-1:0]         i_pos_x,
    input  logic [COORD_BITS-1:0]         i_pos_y,
    input  logic [COORD_BITS-1:0]         i_pos_z,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [HCI_CODE_BITS-1:0]      o_hilbert_code,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [HCI_CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [HCI_CFG_DATA_BITS-1:0]  i_cfg_data
);

    t_cfg                  cfg;
    logic                  valid_s [0:HCI_STAGES];
    logic                  ready_s [0:HCI_STAGES];
    logic [COORD_BITS-1:0] px_s    [0:HCI_STAGES];
    logic [COORD_BITS-1:0] py_s    [0:HCI_STAGES];
    logic [COORD_BITS-1:0] pz_s    [0:HCI_STAGES];
    t_tab                  tab_s   [0:HCI_STAGES];
    t_code                 code_s  [0:HCI_STAGES];

    hci_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    assign valid_s[0] = i_valid;
    assign px_s[0]    = i_pos_x;
    assign py_s[0]    = i_pos_y;
    assign pz_s[0]    = i_pos_z;
    assign tab_s[0]   = cfg.three_d ? HCI_TAB_INIT_3D : HCI_TAB_INIT_2D;
    assign code_s[0]  = '0;

    genvar s;
    generate
        for (s = 0; s < HCI_STAGES; s++) begin : g_stage
            t_hs hs_up;
            assign hs_up.valid = valid_s[s];
            assign hs_up.ready = ready_s[s+1];

            hci_stage #(
                .COORD_BITS  (COORD_BITS),
                .FIRST_LEVEL (s * HCI_LEVELS_PER_STAGE)
            ) u_stage (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cfg   (cfg),
                .i_hs_up (hs_up),
                .i_pos_x (px_s[s]),
                .i_pos_y (py_s[s]),
                .i_pos_z (pz_s[s]),
                .i_tab   (tab_s[s]),
                .i_code  (code_s[s]),
                .o_ready (ready_s[s]),
                .o_valid (valid_s[s+1]),
                .o_pos_x (px_s[s+1]),
                .o_pos_y (py_s[s+1]),
                .o_pos_z (pz_s[s+1]),
                .o_tab   (tab_s[s+1]),
                .o_code  (code_s[s+1])
            );
        end
    endgenerate

    assign ready_s[HCI_STAGES] = !i_stall;
    assign o_stall             = !ready_s[0];
    assign o_valid             = valid_s[HCI_STAGES];
    assign o_hilbert_code      = code_s[HCI_STAGES];

endmodule

// ----- src/hci_checker.sv -----
// Port-level checks of the Hilbert index unit, bound to the top level.
module hci_checker
    import hci_pkg::*;
#(
    parameter int COORD_BITS = HCI_COORD_BITS
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic [COORD_BITS-1:0]         i_pos_x,
    input logic [COORD_BITS-1:0]         i_pos_y,
    input logic [COORD_BITS-1:0]         i_pos_z,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [HCI_CODE_BITS-1:0]      o_hilbert_code,
    input logic                          i_cfg_valid,
    input logic                          o_cfg_ready
);

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result offered right after reset");

    // back pressure only comes from a stalled result at the output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("request refused without a stalled result");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_hilbert_code)))
        else $error("stalled result dropped or changed");

    // a refused request holds its point
    a_req_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_stall) |=> (i_valid && $stable(i_pos_x) && $stable(i_pos_y)
                                  && $stable(i_pos_z)))
        else $error("stalled request dropped or changed");

    // configuration writes are never refused
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("configuration write refused");

endmodule

bind hilbert_curve_index_unit hci_checker #(.COORD_BITS(COORD_BITS)) u_hci_checker (.*);
